// ===== hw/rtl/ivs_pkg.sv =====
// Shared types and constants for the indexed vector store.
package ivs_pkg;

  localparam int INDEX_W = 6;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [DATA_W-1:0] EMPTY_CELL = {DATA_W{1'b1}};

  // Command codes carried by an input item.
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_CLEAR_TOP,
    ST_FINISH
  } ivs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic wr_item;
    logic rd_idx;
    logic ptr_load;
    logic rd_next;
    logic shift_wr;
    logic clear_top;
    logic out_load;
  } ivs_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       ovf;
    logic       in_range;
    logic       shift_more;
    logic       out_busy;
  } ivs_status_t;

endpackage

// ===== hw/rtl/ivs_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface ivs_in_if import ivs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [INDEX_W-1:0] index;
  logic [DATA_W-1:0]  value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

interface ivs_out_if import ivs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [DATA_W-1:0]  read_value;
  logic [COUNT_W-1:0] count;
  logic               overflow;

  modport source (output valid, found, read_value, count, overflow, input ready);
  modport sink   (input valid, found, read_value, count, overflow, output ready);
endinterface

// ===== hw/rtl/indexed_vector_store.sv =====
// Top level of the indexed vector store: controller plus datapath.
//
// The in_ch channel carries command items (write, read, remove) with an
// index and a value; the out_ch channel returns one result item per
// command with the found flag, read value, entry count and overflow flag.
// Both are valid/ready channels; an item moves when valid and ready are high.
// Items are handled one at a time. A write or read goes from acceptance
// through the execute and finish states to the result register, and the
// next item is accepted only after that. A remove at index i with count n
// shifts the cells above i one place down, one cell per shift step, as there
// is a single memory port pair: each step reads one cell and writes it one place lower.
// A remove past the count and unused command codes go from execute straight to finish.
// Cell contents live in one RAM; per-cell valid bits cleared at reset make
// unwritten cells read as -1, so the block is ready right after reset.
// Reset also zeroes the count and drops any pending result.
// The result register holds its item while the receiver stalls; the block
// waits to finish the next item until that register is free.
module indexed_vector_store import ivs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ivs_in_if.sink    in_ch,
  ivs_out_if.source out_ch
);

  ivs_ctrl_t   ctrl;
  ivs_status_t status;

  ivs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  ivs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .status         (status),
    .in_command     (in_ch.command),
    .in_index       (in_ch.index),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_found      (out_ch.found),
    .out_read_value (out_ch.read_value),
    .out_count      (out_ch.count),
    .out_overflow   (out_ch.overflow)
  );

endmodule

// ===== hw/rtl/ivs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ivs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ivs_ctrl.sv =====
// Controller state machine that sequences each command item.
module ivs_ctrl import ivs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ivs_status_t status,
  output ivs_ctrl_t   ctrl
);

  ivs_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.cmd == CMD_REMOVE && status.in_range) state_nxt = ST_SHIFT_CHK;
        else state_nxt = ST_FINISH;
      end
      ST_SHIFT_CHK: begin
        state_nxt = status.shift_more ? ST_SHIFT_WR : ST_CLEAR_TOP;
      end
      ST_SHIFT_WR:  state_nxt = ST_SHIFT_CHK;
      ST_CLEAR_TOP: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctrl.latch = in_valid;
      end
      ST_EXEC: begin
        ctrl.wr_item  = (status.cmd == CMD_WRITE) && !status.ovf;
        ctrl.rd_idx   = (status.cmd == CMD_READ) && status.in_range;
        ctrl.ptr_load = (status.cmd == CMD_REMOVE) && status.in_range;
      end
      ST_SHIFT_CHK: ctrl.rd_next   = status.shift_more;
      ST_SHIFT_WR:  ctrl.shift_wr  = 1'b1;
      ST_CLEAR_TOP: ctrl.clear_top = 1'b1;
      ST_FINISH:    ctrl.out_load  = !status.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ivs_datapath.sv =====
// Datapath: item registers, cell memory with valid bits, count and result register.
module ivs_datapath import ivs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ivs_ctrl_t          ctrl,
  output ivs_status_t        status,
  input  logic [1:0]         in_command,
  input  logic [INDEX_W-1:0] in_index,
  input  logic [DATA_W-1:0]  in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [DATA_W-1:0]  out_read_value,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_overflow
);

  // Only the first 2**INDEX_W cells can ever be addressed.
  localparam int CELLS = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);
  localparam int AW    = $clog2(CELLS);
  localparam logic [COUNT_W-1:0] CELLS_C = COUNT_W'(CELLS);

  logic [1:0]         cmd_r;
  logic [INDEX_W-1:0] idx_r;
  logic [DATA_W-1:0]  val_r;
  logic [COUNT_W-1:0] count_r;
  logic [AW-1:0]      ptr_r;
  logic [CELLS-1:0]   valid_r;
  logic               rd_valid_r;
  logic               out_valid_r;
  logic               found_r;
  logic [DATA_W-1:0]  rvalue_r;
  logic [COUNT_W-1:0] ocount_r;
  logic               ovf_r;

  logic [AW-1:0]      idx_addr;
  logic [AW-1:0]      ptr_next;
  logic [COUNT_W-1:0] count_dec;
  logic [AW-1:0]      top_addr;
  logic               in_range;
  logic               ovf;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;
  logic [DATA_W-1:0]  cell_data;

  // Address and compare logic.
  assign idx_addr  = idx_r[AW-1:0];
  assign ptr_next  = ptr_r + AW'(1);
  assign count_dec = count_r - COUNT_W'(1);
  assign top_addr  = count_dec[AW-1:0];
  assign in_range  = COUNT_W'(idx_r) < count_r;
  assign ovf       = COUNT_W'(idx_r) >= CELLS_C;

  assign status.cmd        = cmd_r;
  assign status.ovf        = ovf;
  assign status.in_range   = in_range;
  assign status.shift_more = (COUNT_W'(ptr_r) + COUNT_W'(1)) < count_r;
  assign status.out_busy   = out_valid_r && !out_ready;

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r <= in_command;
      idx_r <= in_index;
      val_r <= in_value;
    end
  end

  // A cell that was never written since reset reads as empty.
  assign cell_data = rd_valid_r ? mem_rdata : EMPTY_CELL;

  // Memory port selection.
  always_comb begin
    mem_we    = ctrl.wr_item || ctrl.shift_wr || ctrl.clear_top;
    mem_waddr = top_addr;
    mem_wdata = EMPTY_CELL;
    if (ctrl.wr_item) begin
      mem_waddr = idx_addr;
      mem_wdata = val_r;
    end else if (ctrl.shift_wr) begin
      mem_waddr = ptr_r;
      mem_wdata = cell_data;
    end
    mem_re    = ctrl.rd_idx || ctrl.rd_next;
    mem_raddr = ctrl.rd_idx ? idx_addr : ptr_next;
  end

  ivs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Per-cell valid bits, read in step with the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_valid_r <= valid_r[mem_raddr];
    end
  end

  // Entry count: a write past the end extends it, a remove drops it by one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.wr_item && !in_range) begin
      count_r <= COUNT_W'(idx_r) + COUNT_W'(1);
    end else if (ctrl.clear_top) begin
      count_r <= count_dec;
    end
  end

  // Shift pointer for a remove.
  always_ff @(posedge clk) begin
    if (ctrl.ptr_load) begin
      ptr_r <= idx_addr;
    end else if (ctrl.shift_wr) begin
      ptr_r <= ptr_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      found_r  <= (cmd_r == CMD_READ) && in_range;
      rvalue_r <= ((cmd_r == CMD_READ) && in_range) ? cell_data : EMPTY_CELL;
      ocount_r <= count_r;
      ovf_r    <= (cmd_r == CMD_WRITE) && ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_read_value = rvalue_r;
  assign out_count      = ocount_r;
  assign out_overflow   = ovf_r;

endmodule

// ===== hw/rtl/ivs_checker.sv =====
// Port-level assertions for the indexed vector store, bound to the top level.
module ivs_checker import ivs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               found,
  input logic [DATA_W-1:0]  read_value,
  input logic [COUNT_W-1:0] count,
  input logic               overflow
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(read_value)
      && $stable(count) && $stable(overflow))
    else $error("stalled result item changed");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // Found and overflow come from different commands.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(found && overflow))
    else $error("found and overflow both set");

  // A result without a hit reads as empty.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> read_value == EMPTY_CELL)
    else $error("miss result does not read as empty");

endmodule

bind indexed_vector_store ivs_checker u_ivs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .found      (out_ch.found),
  .read_value (out_ch.read_value),
  .count      (out_ch.count),
  .overflow   (out_ch.overflow)
);
